[design/didq_pkg.sv]
// Shared types and constants for the deduplicating identifier table.
`timescale 1ns / 1ps
`default_nettype none

package didq_pkg;

  // Width of the identifier fields on the ports.
  localparam int unsigned PORT_ID_BITS = 32;

  // Most results that one group query may produce.
  localparam int unsigned RESULT_LIMIT = 32;
  localparam int unsigned RESULT_CNT_BITS = $clog2(RESULT_LIMIT + 1);

  // Item kinds carried by the func field.
  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_INSERTED = 3'd0,
    STATUS_PRESENT  = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_MATCH    = 3'd3,
    STATUS_NO_MATCH = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

[design/didq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module didq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/dedup_id_table_group_query_unit.sv]
// Top level of the deduplicating identifier table with group query.
//
// Input channel (in_valid / in_stall) carries one word: func, action_id,
// sender_id and receiver_id. A record word (func 0) appends the triple,
// marks an identical stored row instead, or reports the table full. A
// query word (func 1) returns, up to RESULT_LIMIT, the stored rows whose
// action and sender match, in insertion order, with the row's previous
// mark, and marks them; with no match it returns a single no-match word.
// The final result word of each input word has last set.
// Output channel (out_valid / out_stall) is a registered output stage.
// One input word is worked on at a time, one stored row per cycle through
// the row memory. The final result of a word enters the output stage once
// every stored row has been read and compared; a record that finds its
// triple in row i finishes as soon as row i is read and compared. The next
// word can be accepted in the cycle after the final result enters the output
// stage. A query holds each match back until the next match or the end of
// the scan decides its last flag. Every cycle in which the output stage is
// full and stalled pauses the scan. A new word may be accepted while the
// final result still waits in the output stage. Reset empties the table
// at once.
`timescale 1ns / 1ps
`default_nettype none

module dedup_id_table_group_query_unit #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned ID_BITS     = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 func,
  input  wire logic [didq_pkg::PORT_ID_BITS-1:0]    action_id,
  input  wire logic [didq_pkg::PORT_ID_BITS-1:0]    sender_id,
  input  wire logic [didq_pkg::PORT_ID_BITS-1:0]    receiver_id,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output didq_pkg::status_t                         status,
  output logic      [didq_pkg::PORT_ID_BITS-1:0]    match_receiver,
  output logic                                      prior_mark,
  output logic                                      last
);

  import didq_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TW = 3 * ID_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [RESULT_CNT_BITS-1:0] LIMIT_C = RESULT_CNT_BITS'(RESULT_LIMIT);

  // Control and item registers.
  state_t                     state, state_next;
  logic [CW-1:0]              row_count, row_count_next;
  logic [CW-1:0]              idx, idx_next;
  logic                       rd_valid, rd_valid_next;
  logic [AW-1:0]              rd_row, rd_row_next;
  logic [RESULT_CNT_BITS-1:0] k, k_next;
  func_t                      item_func, item_func_next;
  logic [ID_BITS-1:0]         item_act, item_act_next;
  logic [ID_BITS-1:0]         item_snd, item_snd_next;
  logic [ID_BITS-1:0]         item_rcv, item_rcv_next;

  // Held-back query match.
  logic                       pend_valid, pend_valid_next;
  logic [PORT_ID_BITS-1:0]    pend_recv, pend_recv_next;
  logic                       pend_mark, pend_mark_next;

  // Output stage.
  logic                       out_valid_next;
  status_t                    status_next;
  logic [PORT_ID_BITS-1:0]    match_receiver_next;
  logic                       prior_mark_next;
  logic                       last_next;

  // Memory ports.
  logic                       tri_we, mark_we, mem_re;
  logic [AW-1:0]              tri_waddr, mark_waddr;
  logic [TW-1:0]              tri_wdata, tri_rdata;
  logic                       mark_wdata, mark_rdata;

  // Identifier views at the table width.
  logic [ID_BITS-1:0]         act_in, snd_in, rcv_in;
  logic [ID_BITS-1:0]         rd_act, rd_snd, rd_rcv;
  logic [PORT_ID_BITS-1:0]    rd_rcv_port;
  logic                       hit_pair, hit_full, out_free;

  // Bring port identifiers to ID_BITS and stored receivers back to the port width.
  for (genvar b = 0; b < ID_BITS; b++) begin : g_in_id
    if (b < PORT_ID_BITS) begin : g_bit
      assign act_in[b] = action_id[b];
      assign snd_in[b] = sender_id[b];
      assign rcv_in[b] = receiver_id[b];
    end else begin : g_zero
      assign act_in[b] = 1'b0;
      assign snd_in[b] = 1'b0;
      assign rcv_in[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < PORT_ID_BITS; b++) begin : g_out_id
    if (b < ID_BITS) begin : g_bit
      assign rd_rcv_port[b] = rd_rcv[b];
    end else begin : g_zero
      assign rd_rcv_port[b] = 1'b0;
    end
  end

  // Row storage: the identifier triple and the marked flag.
  didq_ram #(
    .WIDTH(TW),
    .DEPTH(TABLE_DEPTH)
  ) u_triple_ram (
    .clk  (clk),
    .we   (tri_we),
    .waddr(tri_waddr),
    .wdata(tri_wdata),
    .re   (mem_re),
    .raddr(idx[AW-1:0]),
    .rdata(tri_rdata)
  );

  didq_ram #(
    .WIDTH(1),
    .DEPTH(TABLE_DEPTH)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .re   (mem_re),
    .raddr(idx[AW-1:0]),
    .rdata(mark_rdata)
  );

  // Compare the row just read against the current item.
  assign rd_act   = tri_rdata[TW-1 -: ID_BITS];
  assign rd_snd   = tri_rdata[2*ID_BITS-1 -: ID_BITS];
  assign rd_rcv   = tri_rdata[ID_BITS-1:0];
  assign hit_pair = (rd_act == item_act) && (rd_snd == item_snd);
  assign hit_full = hit_pair && (rd_rcv == item_rcv);

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Sequencer: scans one row per cycle while output is free, marking behind the scan.
  always_comb begin
    state_next          = state;
    row_count_next      = row_count;
    idx_next            = idx;
    rd_valid_next       = rd_valid;
    rd_row_next         = rd_row;
    k_next              = k;
    item_func_next      = item_func;
    item_act_next       = item_act;
    item_snd_next       = item_snd;
    item_rcv_next       = item_rcv;
    pend_valid_next     = pend_valid;
    pend_recv_next      = pend_recv;
    pend_mark_next      = pend_mark;
    out_valid_next      = out_valid && out_stall;
    status_next         = status;
    match_receiver_next = match_receiver;
    prior_mark_next     = prior_mark;
    last_next           = last;
    tri_we              = 1'b0;
    tri_waddr           = row_count[AW-1:0];
    tri_wdata           = {item_act, item_snd, item_rcv};
    mark_we             = 1'b0;
    mark_waddr          = rd_row;
    mark_wdata          = 1'b1;
    mem_re              = 1'b0;

    case (state)
      ST_IDLE: begin
        rd_valid_next = 1'b0;
        if (in_valid) begin
          item_func_next  = func_t'(func);
          item_act_next   = act_in;
          item_snd_next   = snd_in;
          item_rcv_next   = rcv_in;
          idx_next        = '0;
          k_next          = '0;
          pend_valid_next = 1'b0;
          state_next      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (out_free) begin
          // Issue the read of the next stored row.
          if (idx < row_count) begin
            mem_re        = 1'b1;
            rd_valid_next = 1'b1;
            rd_row_next   = idx[AW-1:0];
            idx_next      = idx + 1'b1;
          end else begin
            rd_valid_next = 1'b0;
          end

          if (rd_valid) begin
            if (item_func == FUNC_RECORD) begin
              // An identical row gets marked and ends the word.
              if (hit_full) begin
                mark_we             = 1'b1;
                out_valid_next      = 1'b1;
                status_next         = STATUS_PRESENT;
                match_receiver_next = '0;
                prior_mark_next     = mark_rdata;
                last_next           = 1'b1;
                rd_valid_next       = 1'b0;
                state_next          = ST_IDLE;
              end
            end else if (hit_pair && (k != LIMIT_C)) begin
              // A new match releases the one held back, which is not the last.
              mark_we = 1'b1;
              if (pend_valid) begin
                out_valid_next      = 1'b1;
                status_next         = STATUS_MATCH;
                match_receiver_next = pend_recv;
                prior_mark_next     = pend_mark;
                last_next           = 1'b0;
              end
              pend_valid_next = 1'b1;
              pend_recv_next  = rd_rcv_port;
              pend_mark_next  = mark_rdata;
              k_next          = k + 1'b1;
            end
          end else if (idx == row_count) begin
            // Scan complete: close the word.
            out_valid_next  = 1'b1;
            last_next       = 1'b1;
            state_next      = ST_IDLE;
            if (item_func == FUNC_RECORD) begin
              match_receiver_next = '0;
              prior_mark_next     = 1'b0;
              if (row_count != DEPTH_C) begin
                tri_we         = 1'b1;
                mark_we        = 1'b1;
                mark_waddr     = row_count[AW-1:0];
                mark_wdata     = 1'b0;
                row_count_next = row_count + 1'b1;
                status_next    = STATUS_INSERTED;
              end else begin
                status_next = STATUS_FULL;
              end
            end else if (pend_valid) begin
              status_next         = STATUS_MATCH;
              match_receiver_next = pend_recv;
              prior_mark_next     = pend_mark;
            end else begin
              status_next         = STATUS_NO_MATCH;
              match_receiver_next = '0;
              prior_mark_next     = 1'b0;
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row_count  <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      row_count  <= row_count_next;
      rd_valid   <= rd_valid_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx            <= idx_next;
    rd_row         <= rd_row_next;
    k              <= k_next;
    item_func      <= item_func_next;
    item_act       <= item_act_next;
    item_snd       <= item_snd_next;
    item_rcv       <= item_rcv_next;
    pend_recv      <= pend_recv_next;
    pend_mark      <= pend_mark_next;
    status         <= status_next;
    match_receiver <= match_receiver_next;
    prior_mark     <= prior_mark_next;
    last           <= last_next;
  end

endmodule

`default_nettype wire
